// File: hdl/vcl_pkg.sv
`timescale 1ns / 1ps

package vcl_pkg;

  // item and register widths
  localparam int DATA_W    = 32;
  localparam int IDX_W     = 8;
  localparam int CFG_IDX_W = 2;

  // line store geometry: one entry per grid column
  localparam int LINE_DEPTH = 256;
  localparam int ADDR_W     = $clog2(LINE_DEPTH);

  // fixed-point format and datapath widths
  localparam int FRAC_BITS = 16;
  localparam int MUL_W     = DATA_W + 1;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int SH_W      = PROD_W - FRAC_BITS;
  localparam int SUM_W     = SH_W + 2;

  // one line store entry holds everything kept for a column
  typedef struct packed {
    logic [DATA_W-1:0] w_prev;
    logic [DATA_W-1:0] w_prev2;
    logic [DATA_W-1:0] a_prev;
    logic [DATA_W-1:0] b_prev;
  } line_word_t;

  // stencil neighborhood handed to the arithmetic unit
  typedef struct packed {
    logic signed [DATA_W-1:0] wc;
    logic signed [DATA_W-1:0] wl;
    logic signed [DATA_W-1:0] wr;
    logic signed [DATA_W-1:0] wu;
    logic signed [DATA_W-1:0] wd;
    logic [DATA_W-1:0]        ac;
    logic [DATA_W-1:0]        ar;
    logic [DATA_W-1:0]        bc;
    logic [DATA_W-1:0]        bd;
  } operands_t;

  // steps of the shared multiplier sequence
  typedef enum logic [2:0] {
    STEP_NONE,
    STEP_X1,
    STEP_X2,
    STEP_Y1,
    STEP_Y2,
    STEP_SX,
    STEP_SY,
    STEP_FIN
  } step_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INV_HX   = 2'd0,
    CFG_INV_HY   = 2'd1,
    CFG_LAST_COL = 2'd2,
    CFG_LAST_ROW = 2'd3
  } cfg_reg_t;

endpackage

// File: hdl/vcl_line_store.sv
`timescale 1ns / 1ps

module vcl_line_store import vcl_pkg::*; (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  line_word_t        wdata,
  input  logic [ADDR_W-1:0] raddr,
  output line_word_t        rdata
);

  line_word_t mem [LINE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read: the data for an address appears in the next cycle
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/vcl_flux_unit.sv
`timescale 1ns / 1ps

module vcl_flux_unit import vcl_pkg::*; (
  input  logic                     clk,
  input  step_t                    step,
  input  operands_t                ops,
  input  logic [DATA_W-1:0]        inv_hx,
  input  logic [DATA_W-1:0]        inv_hy,
  output logic signed [DATA_W-1:0] result
);

  logic [DATA_W-1:0]        op_k;
  logic signed [MUL_W-1:0]  op_d;
  logic signed [PROD_W-1:0] prod;
  logic signed [SH_W-1:0]   prod_sh;
  logic signed [SH_W-1:0]   acc;
  logic signed [DATA_W-1:0] flux_x;
  logic signed [DATA_W-1:0] flux_y;

  function automatic logic signed [MUL_W-1:0] diff(input logic signed [DATA_W-1:0] p,
                                                   input logic signed [DATA_W-1:0] q);
    diff = MUL_W'(p) - MUL_W'(q);
  endfunction

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = $signed(SUM_W'({1'b0, {(DATA_W-1){1'b1}}}));
    lo = -hi - 1;
    if (v > hi) begin
      sat32 = hi[DATA_W-1:0];
    end else if (v < lo) begin
      sat32 = lo[DATA_W-1:0];
    end else begin
      sat32 = v[DATA_W-1:0];
    end
  endfunction

  // arithmetic shift by the fraction width: floor of product / 2^F
  assign prod_sh = prod[PROD_W-1:FRAC_BITS];

  always_comb begin
    case (step)
      STEP_X1: begin
        op_k = ops.ar;
        op_d = diff(ops.wr, ops.wc);
      end
      STEP_X2: begin
        op_k = ops.ac;
        op_d = diff(ops.wc, ops.wl);
      end
      STEP_Y1: begin
        op_k = ops.bd;
        op_d = diff(ops.wd, ops.wc);
      end
      STEP_Y2: begin
        op_k = ops.bc;
        op_d = diff(ops.wc, ops.wu);
      end
      STEP_SX: begin
        op_k = inv_hx;
        op_d = MUL_W'(flux_x);
      end
      STEP_SY: begin
        op_k = inv_hy;
        op_d = MUL_W'(flux_y);
      end
      default: begin
        op_k = '0;
        op_d = '0;
      end
    endcase
  end

  // single shared multiplier, unsigned coefficient times signed operand
  always_ff @(posedge clk) begin
    prod <= $signed({1'b0, op_k}) * op_d;
  end

  // each step consumes the product of the step before
  always_ff @(posedge clk) begin
    case (step)
      STEP_X2:  acc    <= prod_sh;
      STEP_Y1:  flux_x <= sat32(SUM_W'(acc) - SUM_W'(prod_sh));
      STEP_Y2:  acc    <= prod_sh;
      STEP_SX:  flux_y <= sat32(SUM_W'(acc) - SUM_W'(prod_sh));
      STEP_SY:  acc    <= prod_sh;
      STEP_FIN: result <= sat32(-SUM_W'(acc) - SUM_W'(prod_sh));
      default: begin
      end
    endcase
  end

endmodule

// File: hdl/variable_coeff_laplace_stencil_core.sv
`timescale 1ns / 1ps

// Five-point variable-coefficient Laplacian over a grid streamed in raster order. Each item
// is one grid point (w_value, coef_a, coef_b, all Q16.16); the block tracks row and column
// itself from last_col_index and last_row_index, which the user must write through the cfg
// port only while the block is idle; the block itself does not enforce this. The result for
// (r,c) leaves when the item of (r+1,c) comes in, so output runs one row behind input; row 0
// items give no result, items of the last row give a second result (their own pass-through
// value) flagged by run_last. Boundary points pass w through; interior points give
// -(x flux)*inv_hx_squared - (y flux)*inv_hy_squared, each flux and the final value
// saturated to 32 bits, every product rounded toward minus infinity. One item is handled at a
// time: it reads the line store, runs the multiplier steps for an interior point and hands
// its results to the output register, which out_ready can hold back. The sequence follows
// from the line store's single read port (three registered reads per item, columns c, c+1
// and c-1) and from one shared multiplier forming the six products of an interior point in
// turn. The line store is not cleared after reset; the first rows of the grid fill it.

module variable_coeff_laplace_stencil_core import vcl_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  // configuration
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [DATA_W-1:0]        cfg_data,
  // input items
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [DATA_W-1:0] w_value,
  input  logic [DATA_W-1:0]        coef_a,
  input  logic [DATA_W-1:0]        coef_b,
  // result items
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] result_value,
  output logic [IDX_W-1:0]         out_row,
  output logic [IDX_W-1:0]         out_col,
  output logic                     run_last
);

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_RDC  = 13'b0000000000010,
    S_RDR  = 13'b0000000000100,
    S_RDL  = 13'b0000000001000,
    S_X1   = 13'b0000000010000,
    S_X2   = 13'b0000000100000,
    S_Y1   = 13'b0000001000000,
    S_Y2   = 13'b0000010000000,
    S_SX   = 13'b0000100000000,
    S_SY   = 13'b0001000000000,
    S_FIN  = 13'b0010000000000,
    S_OUT1 = 13'b0100000000000,
    S_OUT2 = 13'b1000000000000
  } state_t;

  state_t state;
  state_t state_next;

  // configuration registers
  logic [DATA_W-1:0] inv_hx_squared;
  logic [DATA_W-1:0] inv_hy_squared;
  logic [IDX_W-1:0]  last_col_index;
  logic [IDX_W-1:0]  last_row_index;

  // position of the next item in the grid
  logic [IDX_W-1:0] row_count;
  logic [IDX_W-1:0] col_count;

  // item under work
  logic [IDX_W-1:0]         cur_row;
  logic [IDX_W-1:0]         cur_col;
  logic signed [DATA_W-1:0] w_in;
  logic [DATA_W-1:0]        a_in;
  logic [DATA_W-1:0]        b_in;
  logic                     has_first;
  logic                     has_second;
  logic                     interior;

  // neighbors fetched from the line store
  line_word_t        word_c;
  logic [DATA_W-1:0] w_right;
  logic [DATA_W-1:0] a_right;
  logic [DATA_W-1:0] w_left;

  logic              accept;
  logic              out_free;
  logic              load_first;
  logic              load_second;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  line_word_t        wr_data;
  line_word_t        rd_data;
  operands_t         ops;
  step_t             step;
  logic signed [DATA_W-1:0] stencil_value;

  assign in_ready    = (state == S_IDLE);
  assign accept      = in_valid && in_ready;
  assign out_free    = !out_valid || out_ready;
  assign load_first  = (state == S_OUT1) && has_first && out_free;
  assign load_second = (state == S_OUT2) && out_free;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      inv_hx_squared <= 32'd46603230;
      inv_hy_squared <= 32'd235929600;
      last_col_index <= 8'd160;
      last_row_index <= 8'd180;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_INV_HX:   inv_hx_squared <= cfg_data;
        CFG_INV_HY:   inv_hy_squared <= cfg_data;
        CFG_LAST_COL: last_col_index <= cfg_data[IDX_W-1:0];
        CFG_LAST_ROW: last_row_index <= cfg_data[IDX_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // raster position, advanced as each item is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
    end else if (accept) begin
      if (col_count >= last_col_index) begin
        col_count <= '0;
        row_count <= (row_count >= last_row_index) ? '0 : row_count + IDX_W'(1);
      end else begin
        col_count <= col_count + IDX_W'(1);
      end
    end
  end

  // latch the item and classify the point one row above it
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_row    <= row_count;
      cur_col    <= col_count;
      w_in       <= w_value;
      a_in       <= coef_a;
      b_in       <= coef_b;
      has_first  <= (row_count != '0);
      has_second <= (row_count >= last_row_index);
      // rows 0 and 1 above, column 0 and the last column are boundary
      interior   <= (row_count > IDX_W'(1)) && (col_count != '0) &&
                    (col_count < last_col_index);
    end
  end

  // read order: own column, right neighbor, left neighbor
  always_comb begin
    case (state)
      S_RDR:   rd_addr = ADDR_W'(cur_col + IDX_W'(1));
      S_RDL:   rd_addr = ADDR_W'(cur_col - IDX_W'(1));
      default: rd_addr = ADDR_W'(cur_col);
    endcase
  end

  // own column is written back once its old contents are in hand; the
  // previous row slides into the row-before-last slot
  assign wr_en   = (state == S_RDL);
  assign wr_data = '{w_prev:  w_in,
                     w_prev2: word_c.w_prev,
                     a_prev:  a_in,
                     b_prev:  b_in};

  vcl_line_store u_line_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (ADDR_W'(cur_col)),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // read data arrives in the state after its address
  always_ff @(posedge clk) begin
    case (state)
      S_RDR: word_c <= rd_data;
      S_RDL: begin
        w_right <= rd_data.w_prev;
        a_right <= rd_data.a_prev;
      end
      S_X1:  w_left <= rd_data.w_prev2;
      default: begin
      end
    endcase
  end

  // center of the stencil is the point one row above the incoming item
  assign ops = '{wc: word_c.w_prev,
                 wl: w_left,
                 wr: w_right,
                 wu: word_c.w_prev2,
                 wd: w_in,
                 ac: word_c.a_prev,
                 ar: a_right,
                 bc: word_c.b_prev,
                 bd: b_in};

  always_comb begin
    case (state)
      S_X1:    step = STEP_X1;
      S_X2:    step = STEP_X2;
      S_Y1:    step = STEP_Y1;
      S_Y2:    step = STEP_Y2;
      S_SX:    step = STEP_SX;
      S_SY:    step = STEP_SY;
      S_FIN:   step = STEP_FIN;
      default: step = STEP_NONE;
    endcase
  end

  vcl_flux_unit u_flux_unit (
    .clk    (clk),
    .step   (step),
    .ops    (ops),
    .inv_hx (inv_hx_squared),
    .inv_hy (inv_hy_squared),
    .result (stencil_value)
  );

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_RDC;
        end
      end
      S_RDC:  state_next = S_RDR;
      S_RDR:  state_next = S_RDL;
      S_RDL:  state_next = interior ? S_X1 : S_OUT1;
      S_X1:   state_next = S_X2;
      S_X2:   state_next = S_Y1;
      S_Y1:   state_next = S_Y2;
      S_Y2:   state_next = S_SX;
      S_SX:   state_next = S_SY;
      S_SY:   state_next = S_FIN;
      S_FIN:  state_next = S_OUT1;
      S_OUT1: begin
        // first row items skip straight past the upper result
        if (!has_first || out_free) begin
          state_next = has_second ? S_OUT2 : S_IDLE;
        end
      end
      S_OUT2: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // output register, lets the next item in while a result waits
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_first || load_second) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_first) begin
      result_value <= interior ? stencil_value : $signed(word_c.w_prev);
      out_row      <= cur_row - IDX_W'(1);
      out_col      <= cur_col;
      run_last     <= !has_second;
    end else if (load_second) begin
      // last row passes its own value through
      result_value <= w_in;
      out_row      <= cur_row;
      out_col      <= cur_col;
      run_last     <= 1'b1;
    end
  end

endmodule

// File: hdl/vcl_checker.sv
`timescale 1ns / 1ps

module vcl_checker import vcl_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [DATA_W-1:0] result_value,
  input logic [IDX_W-1:0]         out_row,
  input logic [IDX_W-1:0]         out_col,
  input logic                     run_last
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_value) &&
      $stable(out_row) && $stable(out_col) && $stable(run_last))
    else $error("result changed while stalled");

  // reset leaves no result pending and the input open
  a_reset_state: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("bad state after reset");

  // one item at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken on consecutive cycles");

  // a last-row pair comes out back to back, same column, next row
  a_pair_follows: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !run_last |=> out_valid &&
      (out_col == $past(out_col)) && (out_row == $past(out_row) + 8'd1))
    else $error("second result of a pair missing or misplaced");

endmodule

bind variable_coeff_laplace_stencil_core vcl_checker u_vcl_checker (.*);
